>>> design/bmst_pkg.sv
// Shared types and constants for the Boyer-Moore skip table block.
package bmst_pkg;

  localparam int PATTERN_MAX_DEF = 32;
  localparam int KIND_W          = 2;
  localparam int BYTE_W          = 8;
  localparam int POS_W           = 5;
  localparam int SHIFT_W         = 6;
  localparam int STATUS_W        = 2;
  localparam int CHAR_NUM        = 256;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD = 2'd0,
    KIND_BAD  = 2'd1,
    KIND_GOOD = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_BUILT = 2'd2,
    ST_BEYOND    = 2'd3
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic resp;
    logic g_init;
    logic g_match;
    logic g_step;
    logic g_wr;
    logic c_init;
    logic c_step;
    logic c_next;
    logic set_built;
    logic rd_c;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic build_req;
    logic out_free;
    logic g_end;
    logic eq;
    logic i_zero;
    logic last_zero;
    logic k_eq_i;
    logic c_last;
  } sts_t;

endpackage

>>> design/boyer_moore_skip_tables.sv
// Boyer-Moore skip table block, top level.
// Pattern bytes load one per request; the request with in_final_byte set starts
// the build of the good-suffix table (the bad-character table is kept current as
// bytes arrive). Each load or query is accepted in S_IDLE, then its result enters
// the output register in S_RESP once that register is free or its result is taken;
// the register holds one waiting result while the next request comes in. After a
// final load, in_stall stays high for the build, which uses the single byte
// comparator fed by the two read ports of the pattern memory, with a read state and
// a compare state per compare. Queries before a build return status 2.
module boyer_moore_skip_tables #(
  parameter int PATTERN_MAX = bmst_pkg::PATTERN_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bmst_pkg::KIND_W-1:0]   in_kind,
  input  logic [bmst_pkg::BYTE_W-1:0]   in_byte_value,
  input  logic [bmst_pkg::POS_W-1:0]    in_position,
  input  logic                          in_final_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bmst_pkg::SHIFT_W-1:0]  out_shift,
  output logic [bmst_pkg::STATUS_W-1:0] out_status
);

  bmst_pkg::cmd_t cmd;
  bmst_pkg::sts_t sts;

  bmst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bmst_dp #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_kind       (in_kind),
    .in_byte_value (in_byte_value),
    .in_position   (in_position),
    .in_final_byte (in_final_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_shift     (out_shift),
    .out_status    (out_status)
  );

endmodule

>>> design/bmst_ctrl.sv
// Controller state machine: request handling and table build sequencing.
module bmst_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  bmst_pkg::sts_t  sts,
  output bmst_pkg::cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RESP  = 7'b0000010,
    S_G_RD  = 7'b0000100,
    S_G_CMP = 7'b0001000,
    S_G_WR  = 7'b0010000,
    S_C_RD  = 7'b0100000,
    S_C_CMP = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_RESP;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.resp = 1'b1;
          if (sts.build_req) begin
            cmd.g_init = 1'b1;
            state_nxt  = S_G_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      // good-suffix pass 1: does the tail after i match the pattern head
      S_G_RD: begin
        if (sts.g_end) begin
          cmd.g_match = 1'b1;
          state_nxt   = S_G_WR;
        end else begin
          state_nxt = S_G_CMP;
        end
      end
      S_G_CMP: begin
        if (sts.eq) begin
          cmd.g_step = 1'b1;
          state_nxt  = S_G_RD;
        end else begin
          state_nxt = S_G_WR;
        end
      end
      S_G_WR: begin
        cmd.g_wr = 1'b1;
        if (sts.i_zero) begin
          if (sts.last_zero) begin
            cmd.set_built = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            cmd.c_init = 1'b1;
            state_nxt  = S_C_RD;
          end
        end else begin
          state_nxt = S_G_RD;
        end
      end
      // good-suffix pass 2: common suffix lengths
      S_C_RD: begin
        cmd.rd_c  = 1'b1;
        state_nxt = S_C_CMP;
      end
      S_C_CMP: begin
        if (sts.eq && !sts.k_eq_i) begin
          cmd.c_step = 1'b1;
          state_nxt  = S_C_RD;
        end else begin
          cmd.c_next = 1'b1;
          if (sts.c_last) begin
            cmd.set_built = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            state_nxt = S_C_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> design/bmst_dp.sv
// Datapath: pattern memory, character tables, suffix table, counters, result register.
module bmst_dp #(
  parameter int PATTERN_MAX = bmst_pkg::PATTERN_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bmst_pkg::cmd_t                cmd,
  output bmst_pkg::sts_t                sts,
  input  logic [bmst_pkg::KIND_W-1:0]   in_kind,
  input  logic [bmst_pkg::BYTE_W-1:0]   in_byte_value,
  input  logic [bmst_pkg::POS_W-1:0]    in_position,
  input  logic                          in_final_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bmst_pkg::SHIFT_W-1:0]  out_shift,
  output logic [bmst_pkg::STATUS_W-1:0] out_status
);

  localparam int LW  = $clog2(PATTERN_MAX + 1);
  localparam int IW  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int SW  = bmst_pkg::SHIFT_W;
  localparam int SW1 = bmst_pkg::SHIFT_W + 1;

  logic [bmst_pkg::BYTE_W-1:0]  pat_mem [PATTERN_MAX];
  logic [bmst_pkg::POS_W-1:0]   last_mem [bmst_pkg::CHAR_NUM];
  logic [SW-1:0]                sfx_mem [PATTERN_MAX];
  logic [bmst_pkg::CHAR_NUM-1:0] seen_r;

  logic [LW-1:0] len_r;
  logic          built_r;
  logic [IW-1:0] i_r;
  logic [LW-1:0] k_r;
  logic [LW-1:0] edge_r;

  logic [bmst_pkg::KIND_W-1:0]  kind_r;
  logic                         final_r;
  logic [bmst_pkg::POS_W-1:0]   pos_r;
  logic                         full_r;
  logic                         seen_q_r;
  logic [bmst_pkg::POS_W-1:0]   last_q_r;
  logic [SW-1:0]                sfx_q_r;
  logic [bmst_pkg::BYTE_W-1:0]  rd_a_r;
  logic [bmst_pkg::BYTE_W-1:0]  rd_b_r;

  logic                          out_valid_r;
  logic [SW-1:0]                 out_shift_r;
  logic [bmst_pkg::STATUS_W-1:0] out_status_r;

  logic          ld;
  logic          room;
  logic          ld_store;
  logic [IW-1:0] store_idx;
  logic [IW-1:0] last_w;
  logic [LW-1:0] start_w;
  logic [IW-1:0] addr_a;
  logic [IW-1:0] addr_b;
  logic          sfx_we;
  logic [IW-1:0] sfx_wa;
  logic [SW-1:0] sfx_wd;
  logic [SW-1:0] res_shift;
  logic [bmst_pkg::STATUS_W-1:0] res_status;

  assign ld        = cmd.accept && (in_kind == bmst_pkg::KIND_LOAD);
  assign room      = built_r || (len_r != LW'(PATTERN_MAX));
  assign ld_store  = ld && room;
  assign store_idx = built_r ? '0 : IW'(len_r);
  assign last_w    = IW'(len_r - LW'(1));
  assign start_w   = LW'(i_r) + LW'(1);

  assign addr_a = cmd.rd_c ? (i_r - IW'(k_r)) : IW'(k_r);
  assign addr_b = cmd.rd_c ? (last_w - IW'(k_r)) : IW'(start_w + k_r);

  // status to controller
  assign sts.build_req = (kind_r == bmst_pkg::KIND_LOAD) && final_r;
  assign sts.out_free  = !out_valid_r || !out_stall;
  assign sts.g_end     = ({1'b0, start_w} + {1'b0, k_r}) >= {1'b0, len_r};
  assign sts.eq        = (rd_a_r == rd_b_r);
  assign sts.i_zero    = (i_r == '0);
  assign sts.last_zero = (last_w == '0);
  assign sts.k_eq_i    = (k_r == LW'(i_r));
  assign sts.c_last    = (IW'(i_r + IW'(1)) == last_w);

  // pattern store: one write, two registered reads
  always_ff @(posedge clk) begin
    if (ld_store) begin
      pat_mem[store_idx] <= in_byte_value;
    end
    rd_a_r <= pat_mem[addr_a];
    rd_b_r <= pat_mem[addr_b];
  end

  // bad-character table kept current as bytes are stored
  always_ff @(posedge clk) begin
    if (ld_store) begin
      last_mem[in_byte_value] <= bmst_pkg::POS_W'(store_idx);
    end
    if (cmd.accept) begin
      last_q_r <= last_mem[in_byte_value];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else if (ld_store) begin
      if (built_r) begin
        seen_r <= bmst_pkg::CHAR_NUM'(1) << in_byte_value;
      end else begin
        seen_r[in_byte_value] <= 1'b1;
      end
    end
  end

  // suffix table write: pass 1 writes entry i, pass 2 fixes entry last-k on a mismatch
  always_comb begin
    sfx_we = 1'b0;
    sfx_wa = i_r;
    sfx_wd = SW'(SW1'(edge_r) + SW1'(last_w - i_r));
    if (cmd.g_wr) begin
      sfx_we = 1'b1;
    end else if (cmd.c_next && !sts.eq) begin
      sfx_we = 1'b1;
      sfx_wa = last_w - IW'(k_r);
      sfx_wd = SW'(SW1'(k_r) + SW1'(last_w - i_r));
    end
  end

  always_ff @(posedge clk) begin
    if (sfx_we) begin
      sfx_mem[sfx_wa] <= sfx_wd;
    end
    if (cmd.accept) begin
      sfx_q_r <= sfx_mem[in_position[IW-1:0]];
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r   <= in_kind;
      final_r  <= in_final_byte;
      pos_r    <= in_position;
      full_r   <= ld && !room;
      seen_q_r <= seen_r[in_byte_value];
    end
  end

  // pattern length and build flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      built_r <= 1'b0;
    end else begin
      if (ld_store) begin
        len_r <= built_r ? LW'(1) : LW'(len_r + LW'(1));
      end
      if (ld) begin
        built_r <= 1'b0;
      end else if (cmd.set_built) begin
        built_r <= 1'b1;
      end
    end
  end

  // build counters
  always_ff @(posedge clk) begin
    if (cmd.g_init) begin
      i_r <= last_w;
      k_r <= '0;
    end else if (cmd.c_init) begin
      i_r <= '0;
      k_r <= '0;
    end else if (cmd.g_step || cmd.c_step) begin
      k_r <= LW'(k_r + LW'(1));
    end else if (cmd.g_wr) begin
      i_r <= i_r - IW'(1);
      k_r <= '0;
    end else if (cmd.c_next) begin
      i_r <= i_r + IW'(1);
      k_r <= '0;
    end
    if (cmd.g_match) begin
      edge_r <= start_w;
    end
  end

  // result for the captured request
  always_comb begin
    res_shift  = '0;
    res_status = bmst_pkg::ST_OK;
    unique case (kind_r)
      bmst_pkg::KIND_LOAD: begin
        if (full_r) begin
          res_status = bmst_pkg::ST_FULL;
        end
      end
      bmst_pkg::KIND_BAD: begin
        if (!built_r) begin
          res_status = bmst_pkg::ST_NOT_BUILT;
        end else if (seen_q_r) begin
          res_shift = SW'(len_r) - SW'(1) - SW'(last_q_r);
        end else begin
          res_shift = SW'(len_r);
        end
      end
      bmst_pkg::KIND_GOOD: begin
        if (!built_r) begin
          res_status = bmst_pkg::ST_NOT_BUILT;
        end else if (SW'(pos_r) >= SW'(len_r)) begin
          res_status = bmst_pkg::ST_BEYOND;
        end else begin
          res_shift = sfx_q_r;
        end
      end
      bmst_pkg::KIND_NONE: begin
        res_shift  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.resp) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp) begin
      out_shift_r  <= res_shift;
      out_status_r <= res_status;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_shift  = out_shift_r;
  assign out_status = out_status_r;

endmodule

>>> design/bmst_chk.sv
// Port-level checks for the Boyer-Moore skip table block, with bind.
module bmst_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [bmst_pkg::KIND_W-1:0]   in_kind,
  input logic [bmst_pkg::BYTE_W-1:0]   in_byte_value,
  input logic [bmst_pkg::POS_W-1:0]    in_position,
  input logic                          in_final_byte,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [bmst_pkg::SHIFT_W-1:0]  out_shift,
  input logic [bmst_pkg::STATUS_W-1:0] out_status
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_shift) && $stable(out_status))
    else $error("result changed while stalled");

  // flagged results carry no shift
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != bmst_pkg::ST_OK) |-> out_shift == '0)
    else $error("flagged result with nonzero shift");

  // one request in flight: the block stalls right after it takes a request
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted back to back");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind boyer_moore_skip_tables bmst_chk u_bmst_chk (.*);

>>> tb/tb_top.sv
// Testbench for boyer_moore_skip_tables: random pattern loads and table queries with a scoreboard.
`timescale 1ns / 100ps

module tb_top;

  class skip_table_scoreboard;
    typedef struct {
      logic [bmst_pkg::SHIFT_W-1:0] shift;
      bmst_pkg::status_t            status;
    } answer_t;

    logic [bmst_pkg::BYTE_W-1:0]  pat [bmst_pkg::PATTERN_MAX_DEF];
    int unsigned                  plen;
    bit                           seen [bmst_pkg::CHAR_NUM];
    logic [bmst_pkg::POS_W-1:0]   last_pos [bmst_pkg::CHAR_NUM];
    logic [bmst_pkg::SHIFT_W-1:0] good_shift [bmst_pkg::PATTERN_MAX_DEF];
    bit                           built;
    answer_t                      answers [$];
    int                           mismatches;
    int                           builds;
    int                           checked;

    function new();
      plen = 0;
      built = 0;
      mismatches = 0;
      builds = 0;
      checked = 0;
      foreach (seen[c]) seen[c] = 0;
    endfunction

    function int pending();
      return answers.size();
    endfunction

    // bytes from start to the end equal the head of the pattern
    function bit tail_is_head(int unsigned start);
      for (int unsigned k = 0; start + k < plen; k++)
        if (pat[k] != pat[start + k]) return 0;
      return 1;
    endfunction

    function int unsigned common_tail(int unsigned at);
      int unsigned k;
      k = 0;
      while (k < at && pat[at - k] == pat[plen - 1 - k]) k++;
      return k;
    endfunction

    function void build_skips();
      int unsigned last, edge_pos, i, len, at;
      last = plen - 1;
      edge_pos = last;
      foreach (seen[c]) seen[c] = 0;
      for (i = 0; i < plen; i++) begin
        seen[pat[i]] = 1;
        last_pos[pat[i]] = i[bmst_pkg::POS_W-1:0];
      end
      i = plen;
      while (i > 0) begin
        i--;
        if (tail_is_head(i + 1)) edge_pos = i + 1;
        good_shift[i] = 6'((edge_pos + (last - i)) & 63);
      end
      for (i = 0; i + 1 < plen; i++) begin
        len = common_tail(i);
        at = last - len;
        if (pat[i - len] != pat[at]) good_shift[at] = 6'((len + (last - i)) & 63);
      end
      built = 1;
      builds++;
    endfunction

    function void note_request(bmst_pkg::kind_t kind, logic [bmst_pkg::BYTE_W-1:0] b,
                               logic [bmst_pkg::POS_W-1:0] p, logic fin);
      answer_t a;
      a.shift = '0;
      a.status = bmst_pkg::ST_OK;
      case (kind)
        bmst_pkg::KIND_LOAD: begin
          if (built) begin
            built = 0;
            plen = 0;
          end
          if (plen < bmst_pkg::PATTERN_MAX_DEF) begin
            pat[plen] = b;
            plen++;
          end else a.status = bmst_pkg::ST_FULL;
          if (fin && plen > 0) build_skips();
        end
        bmst_pkg::KIND_BAD: begin
          if (!built) a.status = bmst_pkg::ST_NOT_BUILT;
          else if (seen[b]) a.shift = 6'(plen - 1 - last_pos[b]);
          else a.shift = 6'(plen);
        end
        bmst_pkg::KIND_GOOD: begin
          if (!built) a.status = bmst_pkg::ST_NOT_BUILT;
          else if (p >= plen) a.status = bmst_pkg::ST_BEYOND;
          else a.shift = good_shift[p];
        end
        default: ;
      endcase
      answers.push_back(a);
    endfunction

    function void check_result(logic [bmst_pkg::SHIFT_W-1:0] shift,
                               logic [bmst_pkg::STATUS_W-1:0] status);
      answer_t a;
      checked++;
      if (answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result with nothing expected: shift %0d status %0d", shift, status);
        return;
      end
      a = answers.pop_front();
      if (shift !== a.shift || status !== a.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d: expected shift %0d status %0d, got shift %0d status %0d",
                   checked, a.shift, a.status, shift, status);
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [bmst_pkg::KIND_W-1:0]   in_kind;
  logic [bmst_pkg::BYTE_W-1:0]   in_byte_value;
  logic [bmst_pkg::POS_W-1:0]    in_position;
  logic                          in_final_byte;
  logic                          out_valid;
  logic                          out_stall;
  logic [bmst_pkg::SHIFT_W-1:0]  out_shift;
  logic [bmst_pkg::STATUS_W-1:0] out_status;

  skip_table_scoreboard        sb;
  bit                          idle_on;
  int                          sent;
  logic [bmst_pkg::BYTE_W-1:0] cur_pat [40];

  boyer_moore_skip_tables uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_kind(in_kind), .in_byte_value(in_byte_value),
    .in_position(in_position), .in_final_byte(in_final_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_shift(out_shift), .out_status(out_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("Timeout waiting for results");
    $display("*** FAILED ***");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= idle_on && ($urandom_range(99) < 10);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_shift, out_status);
  end

  task automatic send(bmst_pkg::kind_t kind, logic [bmst_pkg::BYTE_W-1:0] b,
                      logic [bmst_pkg::POS_W-1:0] p, logic fin);
    if (idle_on && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_byte_value <= b;
    in_position   <= p;
    in_final_byte <= fin;
    do @(posedge clk); while (in_stall);
    sb.note_request(kind, b, p, fin);
    sent++;
  endtask

  // hold off until every outstanding request has answered
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_pattern(int n);
    for (int i = 0; i < n; i++)
      send(bmst_pkg::KIND_LOAD, cur_pat[i], 5'($urandom), i == n - 1);
  endtask

  task automatic query_round(int n, int plen);
    int sel;
    int lim;
    lim = (plen > 32) ? 32 : plen;
    for (int q = 0; q < n; q++) begin
      sel = $urandom_range(99);
      if (sel < 40)
        send(bmst_pkg::KIND_BAD, cur_pat[$urandom_range(lim - 1)], 5'($urandom),
             1'($urandom));
      else if (sel < 55)
        send(bmst_pkg::KIND_BAD, 8'($urandom), 5'($urandom), 1'($urandom));
      else if (sel < 80)
        send(bmst_pkg::KIND_GOOD, 8'($urandom), 5'($urandom_range(lim - 1)), 1'($urandom));
      else if (sel < 94)
        send(bmst_pkg::KIND_GOOD, 8'($urandom), 5'($urandom), 1'($urandom));
      else
        send(bmst_pkg::KIND_NONE, 8'($urandom), 5'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    int plen;
    int mode;
    int unit_len;
    sb = new();
    idle_on = 1'b1;
    sent = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = bmst_pkg::KIND_NONE;
    in_byte_value = '0;
    in_position = '0;
    in_final_byte = 1'b0;
    out_stall = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // before any build, unused kind, single-byte pattern
    send(bmst_pkg::KIND_BAD, 8'h00, 5'd0, 1'b0);
    send(bmst_pkg::KIND_GOOD, 8'hff, 5'd31, 1'b1);
    send(bmst_pkg::KIND_NONE, 8'hff, 5'd31, 1'b1);
    send(bmst_pkg::KIND_LOAD, 8'hff, 5'd31, 1'b1);
    send(bmst_pkg::KIND_BAD, 8'hff, 5'd0, 1'b0);
    send(bmst_pkg::KIND_BAD, 8'h00, 5'd0, 1'b0);
    send(bmst_pkg::KIND_GOOD, 8'h00, 5'd0, 1'b0);
    send(bmst_pkg::KIND_GOOD, 8'h00, 5'd1, 1'b0);
    send(bmst_pkg::KIND_GOOD, 8'h00, 5'd31, 1'b0);
    // periodic pattern, then a load without final leaves tables unbuilt
    send(bmst_pkg::KIND_LOAD, 8'h00, 5'd0, 1'b0);
    send(bmst_pkg::KIND_LOAD, 8'h00, 5'd0, 1'b0);
    send(bmst_pkg::KIND_LOAD, 8'h00, 5'd0, 1'b1);
    send(bmst_pkg::KIND_GOOD, 8'h00, 5'd0, 1'b0);
    send(bmst_pkg::KIND_GOOD, 8'h00, 5'd2, 1'b0);
    send(bmst_pkg::KIND_BAD, 8'h00, 5'd0, 1'b0);
    send(bmst_pkg::KIND_LOAD, 8'h55, 5'd0, 1'b0);
    send(bmst_pkg::KIND_BAD, 8'h55, 5'd0, 1'b0);
    send(bmst_pkg::KIND_GOOD, 8'h55, 5'd0, 1'b0);
    send(bmst_pkg::KIND_LOAD, 8'haa, 5'd0, 1'b1);
    send(bmst_pkg::KIND_GOOD, 8'h00, 5'd0, 1'b0);
    drain();

    while (sent < 650) begin
      idle_on = !(sent > 250 && sent < 400);
      mode = $urandom_range(2);
      case ($urandom_range(9))
        0:       plen = $urandom_range(34, 32);
        1:       plen = $urandom_range(31, 9);
        default: plen = $urandom_range(8, 1);
      endcase
      unit_len = $urandom_range(3, 1);
      for (int i = 0; i < plen; i++)
        case (mode)
          0: cur_pat[i] = 8'($urandom);
          1: cur_pat[i] = $urandom_range(1) ? 8'h61 : 8'h62;
          default: cur_pat[i] = (i < unit_len) ? 8'($urandom_range(99, 97))
                                               : cur_pat[i - unit_len];
        endcase
      if ($urandom_range(9) == 0) begin
        // early query in the middle of a load run
        send(bmst_pkg::KIND_LOAD, cur_pat[0], 5'($urandom), 1'b0);
        query_round(2, 1);
        for (int i = 1; i < plen; i++)
          send(bmst_pkg::KIND_LOAD, cur_pat[i], 5'($urandom), i == plen - 1);
        if (plen == 1) send(bmst_pkg::KIND_LOAD, cur_pat[0], 5'd0, 1'b1);
      end else
        load_pattern(plen);
      query_round($urandom_range(14, 3), plen);
      if ($urandom_range(19) == 0) drain();
    end

    drain();
    repeat (30) @(posedge clk);
    $display("Covered %0d requests across %0d table builds, %0d results checked.",
             sent, sb.builds, sb.checked);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/bmst_pkg.sv
design/bmst_ctrl.sv
design/bmst_dp.sv
design/boyer_moore_skip_tables.sv
design/bmst_chk.sv
tb/tb_top.sv
